### design/stft_magnitude_frames_macros.svh
// assertion macros shared by the stft magnitude design
`ifndef STFT_MAGNITUDE_FRAMES_MACROS_SVH
`define STFT_MAGNITUDE_FRAMES_MACROS_SVH

// same-cycle implication, disabled in reset
`define STFT_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("stft implication failed");

// next-cycle implication, disabled in reset
`define STFT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("stft next-cycle check failed");

`endif

### design/stft_pkg.sv
// shared types, constants and twiddle/window tables for the stft magnitude block
package stft_pkg;

	localparam int FRAME_LEN  = 64;
	localparam int TWO_N      = 2 * FRAME_LEN;
	localparam int ADDR_W     = $clog2(FRAME_LEN);
	localparam int NUM_BINS   = FRAME_LEN / 2 + 1;
	localparam int BIN_W      = 6;
	localparam int HOP_W      = 7;
	localparam int HOP_RESET  = 16;
	localparam int SEEN_W     = 17;
	localparam int FIDX_W     = 16;
	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = 21;
	localparam int XW_W       = 32;
	localparam int PROD_W     = 48;
	localparam int ACC_W      = 54;
	localparam int AR_W       = 30;
	localparam int SQ_W       = 2 * AR_W + 1;
	localparam int ROOT_W     = 31;
	localparam int ROOT_STEPS = (SQ_W + 1) / 2;

	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint PI_Q30  = 64'sd3373259426;

	// table selectors
	localparam int ROM_COS = 0;
	localparam int ROM_SIN = 1;
	localparam int ROM_WIN = 2;

	typedef logic signed [SAMPLE_W-1:0] q15_rom_t [FRAME_LEN];

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [FIDX_W-1:0] frame_index;
		logic [BIN_W-1:0]  bin_index;
		logic [MAG_W-1:0]  magnitude;
		logic              last_bin;
	} out_word_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              issue;
		logic              first;
		logic              last;
		logic [ADDR_W-1:0] rd_addr;
		logic [ADDR_W-1:0] n;
		logic [ADDR_W-1:0] tw;
	} dp_cmd_t;

	typedef struct packed {
		logic bin_done;
	} dp_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_WAIT,
		ST_OUT
	} state_t;

	function automatic longint mul_q30(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint to_q15(input longint v);
		longint t;
		longint r;
		t = v;
		if (t < -ONE_Q30) t = -ONE_Q30;
		if (t > ONE_Q30) t = ONE_Q30;
		r = (((t + ONE_Q30) + (64'sd1 <<< 14)) >>> 15) - 64'sd32768;
		if (r > 64'sd32767) r = 64'sd32767;
		return r;
	endfunction

	// elaboration-time sin/cos in q30 by quadrant reduction and taylor series
	function automatic q15_rom_t build_rom(input int sel);
		q15_rom_t rom;
		longint q, d, ad, a, a2, ts, tc, s, c, cs, sn, w;
		for (int m = 0; m < FRAME_LEN; m++) begin
			q  = (64'sd8 * m + FRAME_LEN) / TWO_N;
			d  = 64'sd4 * m - q * FRAME_LEN;
			ad = (d < 0) ? -d : d;
			a  = (PI_Q30 * ad + FRAME_LEN) / TWO_N;
			a2 = mul_q30(a, a);
			s  = a;
			c  = ONE_Q30;
			ts = mul_q30(a, a2) / 6;       tc = mul_q30(ONE_Q30, a2) / 2;
			s  = s - ts;                   c  = c - tc;
			ts = mul_q30(ts, a2) / 20;     tc = mul_q30(tc, a2) / 12;
			s  = s + ts;                   c  = c + tc;
			ts = mul_q30(ts, a2) / 42;     tc = mul_q30(tc, a2) / 30;
			s  = s - ts;                   c  = c - tc;
			ts = mul_q30(ts, a2) / 72;     tc = mul_q30(tc, a2) / 56;
			s  = s + ts;                   c  = c + tc;
			ts = mul_q30(ts, a2) / 110;    tc = mul_q30(tc, a2) / 90;
			s  = s - ts;                   c  = c - tc;
			ts = mul_q30(ts, a2) / 156;    tc = mul_q30(tc, a2) / 132;
			s  = s + ts;                   c  = c + tc;
			if (d < 0) s = -s;
			case (q % 4)
				0: begin cs = c;  sn = s;  end
				1: begin cs = -s; sn = c;  end
				2: begin cs = -c; sn = -s; end
				default: begin cs = s; sn = -c; end
			endcase
			if (sel == ROM_COS) begin
				rom[m] = SAMPLE_W'(to_q15(cs));
			end else if (sel == ROM_SIN) begin
				rom[m] = SAMPLE_W'(to_q15(sn));
			end else begin
				if (cs > ONE_Q30) cs = ONE_Q30;
				if (cs < -ONE_Q30) cs = -ONE_Q30;
				w = ((ONE_Q30 - cs) + (64'sd1 <<< 15)) >>> 16;
				if (w > 64'sd32767) w = 64'sd32767;
				rom[m] = SAMPLE_W'(w);
			end
		end
		return rom;
	endfunction

	localparam q15_rom_t COS_ROM = build_rom(ROM_COS);
	localparam q15_rom_t SIN_ROM = build_rom(ROM_SIN);
	localparam q15_rom_t WIN_ROM = build_rom(ROM_WIN);

endpackage

### design/stft_ram.sv
// generic single-port-write, registered-read ram
module stft_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### design/stft_sqrt.sv
// iterative integer square root, one result bit per cycle
module stft_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [stft_pkg::SQ_W-1:0] radicand,
	output logic                      done,
	output logic [stft_pkg::ROOT_W-1:0] root
);
	import stft_pkg::*;

	localparam int CNT_W = $clog2(ROOT_STEPS);

	logic [SQ_W-1:0]  rem_q, res_q, bit_q, trial;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];
endmodule

### design/stft_dp.sv
// datapath: sample ring, windowed dft mac pipeline and magnitude
module stft_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stft_pkg::dp_cmd_t                 cmd,
	input  logic signed [stft_pkg::SAMPLE_W-1:0] sample,
	output stft_pkg::dp_stat_t                stat,
	output logic [stft_pkg::MAG_W-1:0]        magnitude
);
	import stft_pkg::*;

	localparam int RND_W = ROOT_W + 1 - 8;

	logic [SAMPLE_W-1:0]        rdata;
	logic                       valid_s1, first_s1, last_s1;
	logic signed [SAMPLE_W-1:0] win_s1, cos_s1, sin_s1;
	logic                       valid_s2, first_s2, last_s2;
	logic signed [XW_W-1:0]     xw_s2;
	logic signed [SAMPLE_W-1:0] cos_s2, sin_s2;
	logic                       valid_s3, first_s3, last_s3;
	logic signed [PROD_W-1:0]   pre_s3, pim_s3;
	logic signed [ACC_W-1:0]    acc_re_q, acc_im_q;
	logic                       fin_s4, fin_s5, fin_s6, fin_s7;
	logic [AR_W-1:0]            ar_s5, ai_s5;
	logic [2*AR_W-1:0]          sqr_s6, sqi_s6;
	logic [SQ_W-1:0]            sum_s7;
	logic                       root_done;
	logic [ROOT_W-1:0]          root;
	logic [RND_W-1:0]           rnd;
	logic [MAG_W-1:0]           mag_q;
	logic                       done_q;

	stft_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME_LEN)) u_ring (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (cmd.wr_addr),
		.wdata (sample),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	// abs of an accumulator rounded half up to 2^-8 lsb
	function automatic logic [AR_W-1:0] abs_q8(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] u;
		logic [ACC_W:0]   t;
		u = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		t = {1'b0, u} + (ACC_W+1)'(64'd1 << 21);
		return t[22 +: AR_W];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			fin_s4   <= 1'b0;
			fin_s5   <= 1'b0;
			fin_s6   <= 1'b0;
			fin_s7   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			fin_s4   <= valid_s3 && last_s3;
			fin_s5   <= fin_s4;
			fin_s6   <= fin_s5;
			fin_s7   <= fin_s6;
			done_q   <= root_done;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		win_s1   <= WIN_ROM[cmd.n];
		cos_s1   <= COS_ROM[cmd.tw];
		sin_s1   <= SIN_ROM[cmd.tw];

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		xw_s2    <= $signed(rdata) * win_s1;
		cos_s2   <= cos_s1;
		sin_s2   <= sin_s1;

		first_s3 <= first_s2;
		last_s3  <= last_s2;
		pre_s3   <= xw_s2 * cos_s2;
		pim_s3   <= xw_s2 * sin_s2;

		if (valid_s3) begin
			if (first_s3) begin
				acc_re_q <= ACC_W'(pre_s3);
				acc_im_q <= ACC_W'(pim_s3);
			end else begin
				acc_re_q <= acc_re_q + ACC_W'(pre_s3);
				acc_im_q <= acc_im_q + ACC_W'(pim_s3);
			end
		end

		ar_s5  <= abs_q8(acc_re_q);
		ai_s5  <= abs_q8(acc_im_q);
		sqr_s6 <= ar_s5 * ar_s5;
		sqi_s6 <= ai_s5 * ai_s5;
		sum_s7 <= SQ_W'(sqr_s6) + SQ_W'(sqi_s6);

		if (root_done) begin
			mag_q <= (rnd > RND_W'((64'd1 << MAG_W) - 1)) ? '1 : MAG_W'(rnd);
		end
	end

	assign rnd = RND_W'((ROOT_W + 1)'(root) + (ROOT_W + 1)'(128) >> 8);

	stft_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fin_s7),
		.radicand (sum_s7),
		.done     (root_done),
		.root     (root)
	);

	assign stat.bin_done = done_q;
	assign magnitude     = mag_q;
endmodule

### design/stft_ctrl.sv
// controller: stream counters, hop register and per-bin sequencing
`include "stft_magnitude_frames_macros.svh"
module stft_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic                        end_of_stream,
	input  logic                        cfg_we,
	input  logic [stft_pkg::HOP_W-1:0]  cfg_wdata,
	output logic                        bin_valid,
	input  logic                        bin_ready,
	output logic [stft_pkg::FIDX_W-1:0] frame_index,
	output logic [stft_pkg::BIN_W-1:0]  bin_index,
	output logic                        last_bin,
	output stft_pkg::dp_cmd_t           cmd,
	input  stft_pkg::dp_stat_t          stat
);
	import stft_pkg::*;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   wr_q, base_q, n_q, rd_q, tw_q, wr_nx;
	logic [SEEN_W-1:0]   seen_q, seen_nx;
	logic [HOP_W-1:0]    phase_q, phase_inc, hop_q, hop_eff;
	logic [FIDX_W-1:0]   fcount_q, fidx_q;
	logic [BIN_W-1:0]    k_q;
	logic [ADDR_W:0]     tw_sum;
	logic                accept, emit, bin_take, at_last_n, at_last_k;

	assign accept    = (state_q == ST_IDLE) && sample_valid;
	assign seen_nx   = (seen_q == '1) ? seen_q : seen_q + 1'b1;
	assign wr_nx     = (wr_q == ADDR_W'(FRAME_LEN - 1)) ? '0 : wr_q + 1'b1;
	assign phase_inc = phase_q + 1'b1;
	assign hop_eff   = (hop_q == '0) ? HOP_W'(1) : hop_q;
	assign emit      = (seen_nx == SEEN_W'(FRAME_LEN)) ||
		((seen_nx > SEEN_W'(FRAME_LEN)) && (phase_inc >= hop_eff));
	assign bin_take  = bin_valid && bin_ready;
	assign at_last_n = (n_q == ADDR_W'(FRAME_LEN - 1));
	assign at_last_k = (k_q == BIN_W'(NUM_BINS - 1));
	assign tw_sum    = (ADDR_W + 1)'(tw_q) + (ADDR_W + 1)'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && emit) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (at_last_n) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.bin_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (bin_ready) state_d = at_last_k ? ST_IDLE : ST_MAC;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			seen_q   <= '0;
			phase_q  <= '0;
			fcount_q <= '0;
			hop_q    <= HOP_W'(HOP_RESET);
			base_q   <= '0;
			fidx_q   <= '0;
			k_q      <= '0;
			n_q      <= '0;
			rd_q     <= '0;
			tw_q     <= '0;
		end else begin
			if (cfg_we) hop_q <= cfg_wdata;
			if (accept) begin
				if (emit) begin
					base_q <= wr_nx;
					rd_q   <= wr_nx;
					fidx_q <= fcount_q;
					k_q    <= '0;
					n_q    <= '0;
					tw_q   <= '0;
				end
				if (end_of_stream) begin
					wr_q     <= '0;
					seen_q   <= '0;
					phase_q  <= '0;
					fcount_q <= '0;
				end else begin
					wr_q     <= wr_nx;
					seen_q   <= seen_nx;
					if (seen_nx == SEEN_W'(FRAME_LEN) || emit) begin
						phase_q <= '0;
					end else if (seen_nx > SEEN_W'(FRAME_LEN)) begin
						phase_q <= phase_inc;
					end
					if (emit) fcount_q <= fcount_q + 1'b1;
				end
			end
			if (state_q == ST_MAC) begin
				n_q  <= n_q + 1'b1;
				rd_q <= (rd_q == ADDR_W'(FRAME_LEN - 1)) ? '0 : rd_q + 1'b1;
				tw_q <= (tw_sum >= (ADDR_W + 1)'(FRAME_LEN)) ?
					ADDR_W'(tw_sum - (ADDR_W + 1)'(FRAME_LEN)) : ADDR_W'(tw_sum);
			end
			if (state_q == ST_OUT && bin_ready && !at_last_k) begin
				k_q  <= k_q + 1'b1;
				n_q  <= '0;
				rd_q <= base_q;
				tw_q <= '0;
			end
		end
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign bin_valid    = (state_q == ST_OUT);
	assign frame_index  = fidx_q;
	assign bin_index    = k_q;
	assign last_bin     = at_last_k;

	assign cmd.wr_en   = accept;
	assign cmd.wr_addr = wr_q;
	assign cmd.issue   = (state_q == ST_MAC);
	assign cmd.first   = (n_q == '0);
	assign cmd.last    = at_last_n;
	assign cmd.rd_addr = rd_q;
	assign cmd.n       = n_q;
	assign cmd.tw      = tw_q;

	`STFT_ASSERT_IMP(a_no_in_while_out, clk, arst_n, bin_valid, !sample_ready)
	`STFT_ASSERT_NEXT(a_idle_after_last, clk, arst_n, bin_take && last_bin, sample_ready)
	`STFT_ASSERT_IMP(a_done_in_wait, clk, arst_n, stat.bin_done, state_q == ST_WAIT)
endmodule

### design/stft_magnitude_frames.sv
// top level of the streaming stft magnitude block
// channels: sample_* carries one padded q1.15 sample word plus an
// end-of-stream flag; bin_* returns one magnitude word per bin,
// bins 0..32 of a frame in order, last_bin set on bin 32.
// cfg_we/cfg_wdata write hop_size (reset 16, 0 acts as 1).
// a sample that completes no frame leaves the block idle and ready.
// the 64th sample since reset or end of stream, and every hop_size
// samples after, start a frame: each bin runs through the
// shared dual mac (ring read, window, cos and sin products), the
// pipeline and squaring, the bit-serial square root and the result
// register, and the next bin starts only once the previous bin word
// is taken.
// sample_ready stays low until the last bin word of the frame is taken.
// a stalled receiver holds the bin word in its output register and the
// block waits; nothing is lost or repeated.
// reset clears all counters and sets hop_size back to 16; the ring needs
// no clear because a frame only reads samples written since the last clear.
module stft_magnitude_frames (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  stft_pkg::in_word_t     sample_word,
	output logic                   bin_valid,
	input  logic                   bin_ready,
	output stft_pkg::out_word_t    bin_word,
	input  logic                   cfg_we,
	input  logic [stft_pkg::HOP_W-1:0] cfg_wdata
);
	import stft_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// controller owns counters and bin sequencing
	stft_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.end_of_stream (sample_word.end_of_stream),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.bin_valid     (bin_valid),
		.bin_ready     (bin_ready),
		.frame_index   (bin_word.frame_index),
		.bin_index     (bin_word.bin_index),
		.last_bin      (bin_word.last_bin),
		.cmd           (cmd),
		.stat          (stat)
	);

	// datapath holds the ring, mac pipeline and magnitude register
	stft_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (sample_word.sample),
		.stat      (stat),
		.magnitude (bin_word.magnitude)
	);
endmodule

### verif/tb_stft_magnitude_frames.sv
// self-checking testbench for the streaming stft magnitude block
module tb_stft_magnitude_frames;
	import stft_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int RAND_ITEMS  = 90;
	localparam int SETTLE      = 20;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_ready;
	in_word_t             sample_word;
	logic                 bin_valid;
	logic                 bin_ready;
	out_word_t            bin_word;
	logic                 cfg_we;
	logic [HOP_W-1:0]     cfg_wdata;

	// local copy of the q1.15 tables, built the same way as the block's roms
	int cos_tab [FRAME_LEN];
	int sin_tab [FRAME_LEN];
	int win_tab [FRAME_LEN];

	// predictor state
	logic signed [SAMPLE_W-1:0] ring_copy [FRAME_LEN];
	int                         seen_cnt;
	int                         phase_cnt;
	int                         frame_cnt;
	int                         wr_ptr;
	int                         hop_reg;

	out_word_t expected_bins [$];

	int errors;
	int cycles;
	int words_sent;
	int words_checked;
	int frames_seen;
	bit quiet_sender;
	bit quiet_receiver;
	int stall_left;

	stft_magnitude_frames dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.bin_valid    (bin_valid),
		.bin_ready    (bin_ready),
		.bin_word     (bin_word),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bin words still expected",
				cycles, expected_bins.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// q30 product with round half up, operands are never negative here
	function automatic longint q30_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// q30 value clamped to +-1 and rounded to q1.15
	function automatic int q30_to_q15(longint v);
		longint r;
		if (v < -ONE_Q30) v = -ONE_Q30;
		if (v > ONE_Q30) v = ONE_Q30;
		r = (((v + ONE_Q30) + (64'sd1 <<< 14)) >>> 15) - 64'sd32768;
		if (r > 32767) r = 32767;
		return int'(r);
	endfunction

	// quadrant reduction plus seven taylor terms for sin and cos of 2*pi*m/N
	function automatic void build_tables();
		longint q, d, ad, a, a2, ts, tc, s, c, cs, sn, w;
		for (int m = 0; m < FRAME_LEN; m++) begin
			q  = (64'sd8 * m + FRAME_LEN) / (2 * FRAME_LEN);
			d  = 64'sd4 * m - q * FRAME_LEN;
			ad = (d < 0) ? -d : d;
			a  = (PI_Q30 * ad + FRAME_LEN) / (2 * FRAME_LEN);
			a2 = q30_mul(a, a);
			ts = a;
			tc = ONE_Q30;
			s  = a;
			c  = ONE_Q30;
			for (int i = 1; i <= 6; i++) begin
				ts = q30_mul(ts, a2) / ((2 * i) * (2 * i + 1));
				tc = q30_mul(tc, a2) / ((2 * i - 1) * (2 * i));
				if (i % 2 == 1) begin
					s = s - ts;
					c = c - tc;
				end else begin
					s = s + ts;
					c = c + tc;
				end
			end
			if (d < 0) s = -s;
			case (q % 4)
				0: begin cs = c;  sn = s;  end
				1: begin cs = -s; sn = c;  end
				2: begin cs = -c; sn = -s; end
				default: begin cs = s; sn = -c; end
			endcase
			cos_tab[m] = q30_to_q15(cs);
			sin_tab[m] = q30_to_q15(sn);
			if (cs > ONE_Q30) cs = ONE_Q30;
			if (cs < -ONE_Q30) cs = -ONE_Q30;
			w = ((ONE_Q30 - cs) + (64'sd1 <<< 15)) >>> 16;
			win_tab[m] = (w > 32767) ? 32767 : int'(w);
		end
	endfunction

	// floor square root, bit by bit
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// |v| at 2^30 scale rounded to 2^-8 lsb
	function automatic longint unsigned abs_to_q8(longint v);
		longint unsigned u;
		u = (v < 0) ? longint'(-v) : longint'(v);
		return (u + (64'd1 << 21)) >> 22;
	endfunction

	// windowed dft of the current ring, one expected word per bin 0..N/2
	task automatic queue_spectrum();
		longint xw [FRAME_LEN];
		longint re, im;
		longint unsigned ar, ai, mag;
		out_word_t w;
		int idx;
		for (int n = 0; n < FRAME_LEN; n++) begin
			idx   = (wr_ptr + n) % FRAME_LEN;
			xw[n] = longint'(ring_copy[idx]) * win_tab[n];
		end
		for (int k = 0; k < NUM_BINS; k++) begin
			re = 0;
			im = 0;
			for (int n = 0; n < FRAME_LEN; n++) begin
				re += xw[n] * cos_tab[(k * n) % FRAME_LEN];
				im += xw[n] * sin_tab[(k * n) % FRAME_LEN];
			end
			ar  = abs_to_q8(re);
			ai  = abs_to_q8(im);
			mag = (floor_sqrt(ar * ar + ai * ai) + 128) >> 8;
			if (mag > 2097151) mag = 2097151;
			w.frame_index = frame_cnt[FIDX_W-1:0];
			w.bin_index   = BIN_W'(k);
			w.magnitude   = MAG_W'(mag);
			w.last_bin    = (k == NUM_BINS - 1);
			expected_bins.insert(expected_bins.size(), w);
		end
		frame_cnt = (frame_cnt + 1) % 65536;
		frames_seen++;
	endtask

	// advance the predictor by one accepted sample word
	task automatic predict_sample(in_word_t w);
		int hop;
		hop = (hop_reg == 0) ? 1 : hop_reg;
		ring_copy[wr_ptr] = w.sample;
		wr_ptr = (wr_ptr + 1) % FRAME_LEN;
		if (seen_cnt < 131071) seen_cnt++;
		if (seen_cnt == FRAME_LEN) begin
			phase_cnt = 0;
			queue_spectrum();
		end else if (seen_cnt > FRAME_LEN) begin
			phase_cnt = (phase_cnt + 1) % 128;
			if (phase_cnt >= hop) begin
				phase_cnt = 0;
				queue_spectrum();
			end
		end
		if (w.end_of_stream) begin
			seen_cnt  = 0;
			phase_cnt = 0;
			frame_cnt = 0;
			wr_ptr    = 0;
		end
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one sample word; called and returns on a falling edge
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic eos);
		int gap;
		in_word_t w;
		gap = quiet_sender ? 0 : pick_gap();
		w.sample        = s;
		w.end_of_stream = eos;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= w;
		do @(posedge clk); while (!sample_ready);
		predict_sample(w);
		words_sent++;
		@(negedge clk);
	endtask

	// wait until every expected bin word has come back, then let the block settle
	task automatic drain();
		sample_valid <= 1'b0;
		while (expected_bins.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// hop register write, only while idle
	task automatic write_hop(int v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= HOP_W'(v);
		@(negedge clk);
		cfg_we    <= 1'b0;
		hop_reg = v;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh7fff;
		if (r == 1) return 16'sh8000;
		if (r == 2) return SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
		return SAMPLE_W'($urandom);
	endfunction

	// receiver: random stalls, a few long ones, none while quiet
	always @(negedge clk) begin
		if (!arst_n || quiet_receiver) begin
			bin_ready  <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			bin_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			bin_ready <= 1'b1;
			if ($urandom_range(0, 99) < 25) stall_left <= $urandom_range(1, 3);
			else if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(20, 80);
		end
	end

	// compare each accepted bin word with the oldest expectation
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && bin_valid && bin_ready) begin
			if (expected_bins.size() == 0) begin
				$error("unexpected bin word frame %0d bin %0d", bin_word.frame_index,
					bin_word.bin_index);
				errors++;
			end else begin
				e = expected_bins.pop_front();
				words_checked++;
				if (bin_word.frame_index !== e.frame_index) begin
					$error("frame_index expected %0d got %0d", e.frame_index,
						bin_word.frame_index);
					errors++;
				end
				if (bin_word.bin_index !== e.bin_index) begin
					$error("bin_index expected %0d got %0d", e.bin_index,
						bin_word.bin_index);
					errors++;
				end
				if (bin_word.magnitude !== e.magnitude) begin
					$error("magnitude expected %0d got %0d (bin %0d)", e.magnitude,
						bin_word.magnitude, e.bin_index);
					errors++;
				end
				if (bin_word.last_bin !== e.last_bin) begin
					$error("last_bin expected %0d got %0d", e.last_bin, bin_word.last_bin);
					errors++;
				end
			end
		end
	end

	// first frame at reset hop, extremes in the samples, then one hop later
	task automatic test_first_frames();
		logic signed [SAMPLE_W-1:0] s;
		quiet_sender   = 1'b1;
		quiet_receiver = 1'b1;
		for (int i = 0; i < FRAME_LEN + HOP_RESET; i++) begin
			case (i % 4)
				0: s = 16'sh7fff;
				1: s = 16'sh8000;
				2: s = 16'sh0000;
				default: s = rand_sample();
			endcase
			send_sample(s, 1'b0);
		end
		quiet_sender   = 1'b0;
		quiet_receiver = 1'b0;
		drain();
	endtask

	// hop of zero behaves like one: a frame on every further sample
	task automatic test_zero_hop();
		write_hop(0);
		for (int i = 0; i < 2; i++) send_sample(rand_sample(), 1'b0);
		drain();
	endtask

	// hop above 64 is taken as given
	task automatic test_long_hop();
		write_hop(70);
		for (int i = 0; i < 70; i++) send_sample(rand_sample(), 1'b0);
		drain();
	endtask

	// shrink the hop after the phase has passed the new value
	task automatic test_hop_shrink();
		write_hop(32);
		for (int i = 0; i < 20; i++) send_sample(rand_sample(), 1'b0);
		write_hop(8);
		for (int i = 0; i < 10; i++) send_sample(rand_sample(), i == 9);
		drain();
	endtask

	// end of stream before a full frame; the next stream restarts at frame zero
	task automatic test_short_stream();
		write_hop(1);
		for (int i = 0; i < 10; i++) send_sample(rand_sample(), i == 9);
		drain();
	endtask

	// constant full scale input: the dc bin is the largest magnitude there is
	task automatic test_full_scale_dc();
		write_hop(64);
		for (int i = 0; i < FRAME_LEN; i++) send_sample(16'sh8000, i == FRAME_LEN - 1);
		drain();
	endtask

	// random streams: random hop, length and content, a few broken off early
	task automatic test_random_streams();
		int hop, len, start;
		start = words_sent;
		while (words_sent - start < RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0: hop = 0;
				1: hop = 127;
				2: hop = $urandom_range(1, 4);
				default: hop = $urandom_range(8, 64);
			endcase
			write_hop(hop);
			quiet_sender   = ($urandom_range(0, 3) == 0);
			quiet_receiver = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) len = $urandom_range(1, FRAME_LEN - 1);
			else len = FRAME_LEN + $urandom_range(0, (hop < 8) ? 6 : 40);
			for (int i = 0; i < len; i++) begin
				// occasional hop change mid-stream
				if (i == FRAME_LEN + 3 && $urandom_range(0, 4) == 0)
					write_hop($urandom_range(2, 40));
				send_sample(rand_sample(), i == len - 1);
			end
		end
		quiet_sender   = 1'b0;
		quiet_receiver = 1'b0;
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		sample_word    = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		errors         = 0;
		cycles         = 0;
		words_sent     = 0;
		words_checked  = 0;
		frames_seen    = 0;
		quiet_sender   = 1'b0;
		quiet_receiver = 1'b0;
		seen_cnt       = 0;
		phase_cnt      = 0;
		frame_cnt      = 0;
		wr_ptr         = 0;
		hop_reg        = HOP_RESET;
		build_tables();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_first_frames();
		test_zero_hop();
		test_long_hop();
		test_hop_shrink();
		test_short_stream();
		test_full_scale_dc();
		test_random_streams();

		drain();
		repeat (200) @(negedge clk);
		$display("sent %0d sample words over hops 0..127 incl. mid-stream changes", words_sent);
		$display("checked %0d bin words from %0d frames", words_checked, frames_seen);
		if (errors == 0 && expected_bins.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
